### hw/rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Sizes, register indexes and helpers shared by the glyph slot cache.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int unsigned SLOTS      = 256;
	localparam int unsigned IDX_W      = $clog2(SLOTS);
	localparam int unsigned CNT_W      = IDX_W + 1;
	localparam int unsigned CODE_W     = 16;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned CPR_W      = 9;
	localparam int unsigned SIU_W      = 9;
	localparam int unsigned SLOT_W     = 8;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned MUL_A_W    = (CPR_W > IDX_W) ? CPR_W : IDX_W;
	localparam int unsigned PROD_W     = MUL_A_W + DIM_W;
	localparam int unsigned DIV_CNT_W  = $clog2(IDX_W) + 1;
	localparam int unsigned COORD_MAX  = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_WIDTH    = 4'd0,
		REG_CELL_HEIGHT   = 4'd1,
		REG_CELLS_PER_ROW = 4'd2,
		REG_SLOTS_IN_USE  = 4'd3
	} cfg_reg_t;

	function automatic logic [DIM_W-1:0] sat_coord(input logic [PROD_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v > PROD_W'(COORD_MAX)) begin
			r = DIM_W'(COORD_MAX);
		end else begin
			r = v[DIM_W-1:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/gsc_ram.sv
// ----------------------------------------------------------------------------
// gsc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gsc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/glyph_slot_cache_fifo.sv
// ----------------------------------------------------------------------------
// glyph_slot_cache_fifo
// Fully associative glyph slot cache with FIFO replacement and atlas rectangle.
// ----------------------------------------------------------------------------
// Each character code is looked up by a serial scan of the slot keys, one key
// per cycle through the single read port of the key RAM. The slot index is then
// divided by cells_per_row in a bit-serial divider, and one shared multiplier
// forms the left and top coordinates. A new code is accepted while the previous
// result word still waits on the output. Configuration is written through
// cfg_valid/cfg_ready and must only change while the block is idle.
// ----------------------------------------------------------------------------
module glyph_slot_cache_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [gsc_pkg::CODE_W-1:0]      char_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [gsc_pkg::SLOT_W-1:0]      slot,
	output logic                            evicted,
	output logic [gsc_pkg::CODE_W-1:0]      evicted_code,
	output logic [gsc_pkg::DIM_W-1:0]       rect_left,
	output logic [gsc_pkg::DIM_W-1:0]       rect_top,
	output logic [gsc_pkg::DIM_W-1:0]       rect_right,
	output logic [gsc_pkg::DIM_W-1:0]       rect_bottom,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import gsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS_RD,
		ST_MISS_WR,
		ST_DIV,
		ST_MUL_COL,
		ST_MUL_ROW,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic [DIM_W-1:0]      cw_q;
	logic [DIM_W-1:0]      ch_q;
	logic [CPR_W-1:0]      cpr_q;
	logic [SIU_W-1:0]      siu_q;
	logic                  valid_q [SLOTS];
	logic [IDX_W-1:0]      fp_q;
	logic [CODE_W-1:0]     code_q;
	logic [CNT_W-1:0]      scan_q;
	logic                  pend_q;
	logic [IDX_W-1:0]      idx_s1;
	logic [IDX_W-1:0]      slot_q;
	logic                  hit_q;
	logic                  ev_q;
	logic [CODE_W-1:0]     evc_q;
	logic [CPR_W-1:0]      rem_q;
	logic [IDX_W-1:0]      dq_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [DIM_W-1:0]      left_q;
	logic [DIM_W-1:0]      top_q;
	logic                  out_valid_q;

	logic [CNT_W-1:0]      n_c;
	logic [CPR_W-1:0]      cpr_c;
	logic [IDX_W-1:0]      sel_c;
	logic [CNT_W-1:0]      fp_inc_c;
	logic [CPR_W-1:0]      trial_c;
	logic                  qbit_c;
	logic [MUL_A_W-1:0]    mul_a_c;
	logic [DIM_W-1:0]      mul_b_c;
	logic [PROD_W-1:0]     prod_c;
	logic [DIM_W:0]        right_sum_c;
	logic [DIM_W:0]        bottom_sum_c;
	logic                  out_free_c;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_raddr;
	logic [CODE_W-1:0]     ram_rdata;
	logic                  match_c;

	gsc_ram #(
		.WIDTH (CODE_W),
		.DEPTH (SLOTS)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (code_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (siu_q == '0) begin
			n_c = CNT_W'(1);
		end else if (32'(siu_q) > SLOTS) begin
			n_c = CNT_W'(SLOTS);
		end else begin
			n_c = CNT_W'(siu_q);
		end
		cpr_c        = (cpr_q == '0) ? CPR_W'(1) : cpr_q;
		sel_c        = ({1'b0, fp_q} >= n_c) ? '0 : fp_q;
		fp_inc_c     = {1'b0, sel_c} + CNT_W'(1);
		trial_c      = {rem_q[CPR_W-2:0], dq_q[IDX_W-1]};
		qbit_c       = (trial_c >= cpr_c);
		mul_a_c      = (state_q == ST_MUL_COL) ? MUL_A_W'(rem_q) : MUL_A_W'(dq_q);
		mul_b_c      = (state_q == ST_MUL_COL) ? cw_q : ch_q;
		prod_c       = PROD_W'(mul_a_c) * PROD_W'(mul_b_c);
		right_sum_c  = {1'b0, left_q} + {1'b0, cw_q};
		bottom_sum_c = {1'b0, top_q} + {1'b0, ch_q};
		out_free_c   = !out_valid_q || !out_stall;
		ram_we       = (state_q == ST_MISS_WR);
		ram_raddr    = (state_q == ST_MISS_RD) ? sel_c : scan_q[IDX_W-1:0];
		match_c      = pend_q && valid_q[idx_s1] && (ram_rdata == code_q);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q  <= DIM_W'(16);
			ch_q  <= DIM_W'(16);
			cpr_q <= CPR_W'(16);
			siu_q <= SIU_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CELL_WIDTH: begin
					cw_q <= cfg_data[DIM_W-1:0];
				end
				REG_CELL_HEIGHT: begin
					ch_q <= cfg_data[DIM_W-1:0];
				end
				REG_CELLS_PER_ROW: begin
					cpr_q <= cfg_data[CPR_W-1:0];
				end
				REG_SLOTS_IN_USE: begin
					siu_q <= cfg_data[SIU_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fp_q        <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						code_q  <= char_code;
						scan_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_s1 <= scan_q[IDX_W-1:0];
					if (match_c) begin
						slot_q    <= idx_s1;
						hit_q     <= 1'b1;
						ev_q      <= 1'b0;
						evc_q     <= '0;
						pend_q    <= 1'b0;
						rem_q     <= '0;
						dq_q      <= idx_s1;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else if (scan_q < n_c) begin
						pend_q <= 1'b1;
						scan_q <= scan_q + CNT_W'(1);
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						state_q <= ST_MISS_RD;
					end
				end
				ST_MISS_RD: begin
					slot_q  <= sel_c;
					hit_q   <= 1'b0;
					fp_q    <= (fp_inc_c >= n_c) ? '0 : fp_inc_c[IDX_W-1:0];
					state_q <= ST_MISS_WR;
				end
				ST_MISS_WR: begin
					ev_q            <= valid_q[slot_q];
					evc_q           <= valid_q[slot_q] ? ram_rdata : '0;
					valid_q[slot_q] <= 1'b1;
					rem_q           <= '0;
					dq_q            <= slot_q;
					div_cnt_q       <= '0;
					state_q         <= ST_DIV;
				end
				ST_DIV: begin
					rem_q     <= qbit_c ? (trial_c - cpr_c) : trial_c;
					dq_q      <= {dq_q[IDX_W-2:0], qbit_c};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(IDX_W - 1)) begin
						state_q <= ST_MUL_COL;
					end
				end
				ST_MUL_COL: begin
					left_q  <= sat_coord(prod_c);
					state_q <= ST_MUL_ROW;
				end
				ST_MUL_ROW: begin
					top_q   <= sat_coord(prod_c);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free_c) begin
						out_valid_q  <= 1'b1;
						hit          <= hit_q;
						slot         <= SLOT_W'(slot_q);
						evicted      <= ev_q;
						evicted_code <= evc_q;
						rect_left    <= left_q;
						rect_top     <= top_q;
						rect_right   <= sat_coord(PROD_W'(right_sum_c));
						rect_bottom  <= sat_coord(PROD_W'(bottom_sum_c));
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("hit result reports an eviction");

	a_evc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted) |-> (evicted_code == '0))
		else $error("evicted code not zero without eviction");

	a_fill_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MISS_WR) |=> valid_q[$past(slot_q)])
		else $error("filled slot not marked valid");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= n_c))
		else $error("key scan ran past the usable slots");
`endif

endmodule
